### hdl/opq_pkg.sv
// Shared types and constants for the ordered priority queue.
// Field widths, status and command codes, and transaction structs.
// No dependencies.
package opq_pkg;

  localparam int TAG_BITS      = 16;
  localparam int PRIORITY_BITS = 8;
  localparam int OCC_BITS      = 5;
  localparam int STATUS_BITS   = 2;

  // result status codes
  localparam logic [STATUS_BITS-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd2;

  // commands
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  typedef struct packed {
    logic [TAG_BITS-1:0]      tag;
    logic [PRIORITY_BITS-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic insert;
    logic remove;
  } cell_ctrl_t;

  typedef struct packed {
    logic                     cmd;
    logic [TAG_BITS-1:0]      item_tag;
    logic [PRIORITY_BITS-1:0] item_priority;
  } item_t;

  typedef struct packed {
    logic [STATUS_BITS-1:0]   status;
    logic [TAG_BITS-1:0]      out_tag;
    logic [PRIORITY_BITS-1:0] out_priority;
    logic [OCC_BITS-1:0]      occupancy;
  } result_t;

endpackage

### hdl/ordered_priority_queue.sv
// Ordered priority queue, a shifting chain of compare cells.
// The result is registered when the command transaction is accepted.
// Throughput: one insert or remove per cycle; the only stall is a held result.
// Reset (rst, synchronous): count and result valid clear; slot contents kept.
// Depends on opq_pkg and opq_cell.
module ordered_priority_queue import opq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  result_t          result_next;

  entry_t                 new_entry;
  entry_t                 cell_entry [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] cell_ge;
  cell_ctrl_t             ctrl;

  logic accept;
  logic full;
  logic empty;
  logic is_insert;

  // A new command is taken unless a finished result is still held.
  assign item_stall = result_valid && result_stall;
  assign accept     = item_valid && !item_stall;

  assign is_insert = (item.cmd == CMD_INSERT);
  assign full      = (count == CNT_W'(QUEUE_DEPTH));
  assign empty     = (count == '0);

  // Full inserts and empty removes leave the chain untouched.
  assign ctrl.insert = accept && is_insert && !full;
  assign ctrl.remove = accept && !is_insert && !empty;

  assign new_entry.tag  = item.item_tag;
  assign new_entry.prio = item.item_priority;

  // Cell chain. Slots below count are live; the compare flags form a
  // prefix of ones, so each cell finds its role from its own flag and
  // its upstream neighbor's: keep, take the new entry, or shift down.
  // A remove shifts every slot one place toward the head.
  genvar i;
  generate
    for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic   occ;
      logic   ge_up;
      entry_t up_entry;
      entry_t down_entry;

      assign occ = (CNT_W'(i) < count);

      if (i == 0) begin : g_head
        assign ge_up    = 1'b1;
        assign up_entry = new_entry;
      end else begin : g_body
        assign ge_up    = cell_ge[i-1];
        assign up_entry = cell_entry[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
        assign down_entry = cell_entry[i];
      end else begin : g_mid
        assign down_entry = cell_entry[i+1];
      end

      opq_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .occupied   (occ),
        .ge_prev    (ge_up),
        .new_entry  (new_entry),
        .prev_entry (up_entry),
        .next_entry (down_entry),
        .entry      (cell_entry[i]),
        .ge         (cell_ge[i])
      );
    end
  endgenerate

  always_comb begin
    count_next = count;
    if (ctrl.insert) begin
      count_next = count + CNT_W'(1);
    end else if (ctrl.remove) begin
      count_next = count - CNT_W'(1);
    end
  end

  // Result of this transaction; head entry is read before it shifts out.
  always_comb begin
    result_next.status       = ST_DONE;
    result_next.out_tag      = '0;
    result_next.out_priority = '0;
    result_next.occupancy    = OCC_BITS'(count_next);
    if (is_insert) begin
      if (full) begin
        result_next.status = ST_FULL;
      end
    end else if (empty) begin
      result_next.status = ST_EMPTY;
    end else begin
      result_next.out_tag      = cell_entry[0].tag;
      result_next.out_priority = cell_entry[0].prio;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

endmodule

### hdl/opq_cell.sv
// One slot of the sorted chain: holds an entry and compares it with
// the incoming priority. Depends on opq_pkg.
module opq_cell import opq_pkg::*; (
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  logic       occupied,
  input  logic       ge_prev,
  input  entry_t     new_entry,
  input  entry_t     prev_entry,
  input  entry_t     next_entry,
  output entry_t     entry,
  output logic       ge
);

  entry_t entry_next;

  // stored entry stays ahead of the new one (equal priority keeps order)
  assign ge = occupied && (entry.prio >= new_entry.prio);

  always_comb begin
    entry_next = entry;
    if (ctrl.insert) begin
      if (!ge) begin
        entry_next = ge_prev ? new_entry : prev_entry;
      end
    end else if (ctrl.remove) begin
      entry_next = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

### hdl/opq_checker.sv
// Port-level checks for the ordered priority queue, bound to the top.
// Depends on opq_pkg and ordered_priority_queue.
module opq_checker import opq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input logic    clk,
  input logic    rst,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.status == ST_DONE || result.status == ST_FULL ||
                      result.status == ST_EMPTY))
    else $error("status code out of range");

  a_zero_payload: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status != ST_DONE) |->
      (result.out_tag == '0 && result.out_priority == '0))
    else $error("rejected transaction carries an entry");

  a_full_occ: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status == ST_FULL) |->
      (result.occupancy == OCC_BITS'(QUEUE_DEPTH)))
    else $error("full status with store not full");

  a_empty_occ: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status == ST_EMPTY) |-> (result.occupancy == '0))
    else $error("empty status with entries stored");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(result)))
    else $error("stalled result changed");

endmodule

bind ordered_priority_queue opq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_opq_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

### tb/ordered_priority_queue_tb.sv
// Testbench for ordered_priority_queue: directed and random insert/remove traffic.
// Expected results come from a sorted-slot model of the queue inside this file.
// Depends on opq_pkg and the ordered_priority_queue RTL.
module ordered_priority_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import opq_pkg::*;

  localparam int QUEUE_DEPTH    = 16;
  // Cycles with no transaction on either channel before the run is abandoned.
  // This is generous against the longest random stall or gap.
  localparam int WATCHDOG_LIMIT = 2000;
  // Settle time after the drain to catch any stray late result.
  localparam int SETTLE_CYCLES  = 5;

  logic    clk          = 1'b0;
  logic    rst          = 1'b1;
  logic    item_valid   = 1'b0;
  logic    item_stall;
  item_t   item         = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  ordered_priority_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Queue model: slots kept sorted by descending priority, FIFO among ties.
  // Only slots below slot_count are ever read.
  // ---------------------------------------------------------------------------
  entry_t              slots [QUEUE_DEPTH];
  logic [OCC_BITS-1:0] slot_count = '0;
  result_t             pending_results [$];
  int                  fail_count = 0;
  int                  quiet_cycles = 0;
  bit                  idle_on = 1'b1;   // random gaps and stalls enabled
  int                  stall_left = 0;

  function automatic result_t model_queue_op(input item_t it);
    result_t r;
    int      pos;
    int      k;
    r = '0;
    r.status = ST_DONE;
    if (it.cmd == CMD_INSERT) begin
      if (slot_count >= QUEUE_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        // new entry goes behind every entry of greater or equal priority
        pos = 0;
        while (pos < slot_count && slots[pos].prio >= it.item_priority) pos++;
        for (k = int'(slot_count); k > pos; k--) slots[k] = slots[k-1];
        slots[pos].tag  = it.item_tag;
        slots[pos].prio = it.item_priority;
        slot_count++;
      end
    end else begin
      if (slot_count == 0) begin
        r.status = ST_EMPTY;
      end else begin
        // hand back the head, then close the gap
        r.out_tag      = slots[0].tag;
        r.out_priority = slots[0].prio;
        for (k = 1; k < slot_count; k++) slots[k-1] = slots[k];
        slot_count--;
      end
    end
    r.occupancy = slot_count;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: predicts on each accepted command transaction and checks each
  // accepted result transaction against the oldest prediction. The command
  // side is handled first so a same-edge result could still find its entry.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (item_valid && !item_stall) pending_results.push_back(model_queue_op(item));
      if (result_valid && !result_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t ns: result with nothing expected, status %0h tag %0h prio %0h occ %0h",
                   $time, result.status, result.out_tag, result.out_priority,
                   result.occupancy);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("status",       32'(want.status),       32'(result.status));
          check_field("out_tag",      32'(want.out_tag),      32'(result.out_tag));
          check_field("out_priority", 32'(want.out_priority), 32'(result.out_priority));
          check_field("occupancy",    32'(want.occupancy),    32'(result.occupancy));
        end
      end
    end
  end

  // Watchdog: any transaction on either channel resets the count.
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: watchdog expired, %0d results outstanding", $time,
               pending_results.size());
      $display("ordered_priority_queue test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Idle lengths: mostly short, now and then long.
  function automatic int pick_idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Result-side backpressure, changed on the falling edge only.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
      if (idle_on && $urandom_range(0, 3) == 0) stall_left = pick_idle_len();
    end
  end

  // Priority mix: full range, a cluster of low values for ties, and the extremes.
  function automatic logic [PRIORITY_BITS-1:0] random_priority();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return PRIORITY_BITS'($urandom_range(0, 255));
    if (r < 70) return PRIORITY_BITS'($urandom_range(0, 3));
    if (r < 85) return '0;
    return '1;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: called at a falling edge, returns at the falling edge after the
  // transaction is accepted. valid stays high between back-to-back items.
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic cmd, input logic [TAG_BITS-1:0] tag,
                           input logic [PRIORITY_BITS-1:0] prio);
    item_t nxt;
    int    gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 99) >= 55) gap = pick_idle_len();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    nxt.cmd           = cmd;
    nxt.item_tag      = tag;
    nxt.item_priority = prio;
    item_valid <= 1'b1;
    item       <= nxt;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Hold the sender off until every predicted result has been seen.
  task automatic drain_results();
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Remove from an empty queue; the tag and priority fields must be ignored.
  task automatic test_remove_empty();
    send_item(CMD_REMOVE, '1, '1);
  endtask

  // Fill to capacity with extreme tags and priorities and several ties,
  // try one insert too many, then pull off the head entries.
  task automatic test_fill_to_full();
    int i;
    send_item(CMD_INSERT, 16'hFFFF, 8'hFF);
    send_item(CMD_INSERT, 16'h0000, 8'h00);
    send_item(CMD_INSERT, 16'h1234, 8'h80);
    send_item(CMD_INSERT, 16'h0001, 8'h80);   // tie behind 16'h1234
    send_item(CMD_INSERT, 16'hFFFE, 8'hFF);   // tie at the top
    send_item(CMD_INSERT, 16'h8000, 8'h00);   // tie at the bottom
    for (i = 0; i < QUEUE_DEPTH - 6; i++)
      send_item(CMD_INSERT, TAG_BITS'(16'h5A00 + i), PRIORITY_BITS'(i * 29));
    send_item(CMD_INSERT, 16'hAAAA, 8'h55);   // rejected, queue full
    repeat (4) send_item(CMD_REMOVE, 16'h0F0F, 8'hF0);
  endtask

  // Random traffic in phases that lean toward insert or remove, so the
  // queue swings between empty and full many times.
  task automatic test_mixed_random(input int n_items);
    int sent;
    int phase_left;
    int insert_pct;
    sent       = 0;
    phase_left = 0;
    insert_pct = 50;
    while (sent < n_items) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(20, 60);
        case ($urandom_range(0, 2))
          0:       insert_pct = 20;
          1:       insert_pct = 50;
          default: insert_pct = 85;
        endcase
      end
      send_item(($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_REMOVE,
                TAG_BITS'($urandom_range(0, 65535)), random_priority());
      phase_left--;
      sent++;
    end
  endtask

  // Sender pause: wait for the queue's results to catch up, then go on.
  task automatic test_pause_until_drained();
    drain_results();
    test_mixed_random(20);
  endtask

  // Fill with only a few distinct priorities, then drain, often past empty,
  // so first-in first-out order among equal priorities is exercised hard.
  task automatic test_tie_ordering(input int n_items);
    int sent;
    int burst;
    int i;
    sent = 0;
    while (sent < n_items) begin
      burst = $urandom_range(4, QUEUE_DEPTH + 2);
      for (i = 0; i < burst; i++)
        send_item(CMD_INSERT, TAG_BITS'($urandom_range(0, 65535)),
                  PRIORITY_BITS'($urandom_range(0, 2) * 100));
      sent += burst;
      burst = $urandom_range(1, QUEUE_DEPTH + 2);
      for (i = 0; i < burst; i++)
        send_item(CMD_REMOVE, TAG_BITS'($urandom_range(0, 65535)), random_priority());
      sent += burst;
    end
  endtask

  // Full-rate stretch: no gaps on the command side, no stalls on results.
  task automatic test_back_to_back(input int n_items);
    idle_on = 1'b0;
    test_mixed_random(n_items);
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_remove_empty();
    test_fill_to_full();
    test_mixed_random(680);
    test_pause_until_drained();
    test_tie_ordering(400);
    test_back_to_back(350);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("ordered_priority_queue test passed");
    end else begin
      $display("ordered_priority_queue test failed");
    end
    $finish;
  end

endmodule
